/* rtl/cbr_pkg.sv */
// Package for the collision push-back resolver: widths, codes and shared
// fixed-point helpers. No dependencies.
package cbr_pkg;

    localparam int CB     = 16;
    localparam int PW     = (3 * CB > 48) ? 3 * CB : 48;
    localparam int AXW    = 16;
    localparam int AF     = 14;
    localparam int RW     = CB + 1;
    localparam int PRW    = RW + AXW;
    localparam int DOTW   = PRW + 2;
    localparam int TW     = CB + 1;
    localparam int QPW    = AXW + TW;
    localparam int ACCW   = QPW + 2;
    localparam int DW     = CB + 6;
    localparam int SQW    = 2 * DW + 2;
    localparam int LW     = SQW / 2;
    localparam int SQ_IT  = SQW / 2;
    localparam int SQ_ST  = (SQ_IT + 1) / 2;
    localparam int QB     = AF + 1;
    localparam int NW     = DW + AF + 2;
    localparam int CW     = CB + 2;
    localparam int SUMW   = CB + 3;
    localparam int DIVK   = SUMW + 1;
    localparam int RECIP3 = ((1 << DIVK) + 2) / 3;
    localparam int OW     = LW + 2;
    localparam int RTW    = 17;
    localparam int EPW    = 8;
    localparam int DRW    = AF + 2;
    localparam int MVW    = DRW + CW + 1;

    localparam logic [RTW-1:0] RATIO_ONE = RTW'(1 << 16);
    localparam logic signed [63:0] CHI = (64'sd1 <<< (CB - 1)) - 64'sd1;
    localparam logic signed [63:0] CLO = -(64'sd1 <<< (CB - 1));

    localparam logic CFG_PUSH_RATIO = 1'b0;
    localparam logic CFG_EPSILON    = 1'b1;

    typedef enum logic [1:0] {
        OP_SS = 2'd0,
        OP_BB = 2'd1,
        OP_SB = 2'd2,
        OP_BS = 2'd3
    } t_op;

    typedef struct packed {
        logic [47:0]         pos_a;
        logic [47:0]         pos_b;
        logic                first_b;
        logic                fb_y;
        logic [CW-1:0]       contact;
        logic [2:0][DW-1:0]  d;
    } t_side;

    typedef struct packed {
        t_side         side;
        logic          short_sep;
        logic          pushed;
        logic [CW-1:0] ov;
    } t_mid;

    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int s);
        logic [63:0] m;
        logic [63:0] r;
        m = v[63] ? 64'(-v) : 64'(v);
        r = (m + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [CB-1:0] fpart(input logic [47:0] f, input int i);
        logic [PW-1:0] e;
        e = PW'(f);
        return e[i*CB +: CB];
    endfunction

    function automatic logic signed [AXW-1:0] axpart(input logic [47:0] f, input int i);
        return $signed(f[i*AXW +: AXW]);
    endfunction

    function automatic logic [CB-1:0] sat_c(input logic signed [63:0] v);
        logic [CB-1:0] r;
        if (v > CHI) begin
            r = CHI[CB-1:0];
        end else if (v < CLO) begin
            r = CLO[CB-1:0];
        end else begin
            r = v[CB-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/cbr_geom.sv */
// Front stages: decode, box projections, clamp and separation vector.
// Depends on cbr_pkg.
module cbr_geom import cbr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_op         i_op,
    input  logic [47:0] i_pos_a,
    input  logic [47:0] i_pos_b,
    input  logic [47:0] i_ext_a,
    input  logic [47:0] i_ext_b,
    input  logic [47:0] i_axis_u,
    input  logic [47:0] i_axis_v,
    input  logic [47:0] i_axis_w,
    output logic        o_valid,
    output t_side       o_side
);

    logic signed [CB-1:0]  n1_pa [3];
    logic signed [CB-1:0]  n1_pb [3];
    logic signed [RW-1:0]  n1_rel [3];
    logic signed [AXW-1:0] n1_ax [3][3];
    logic [CB-1:0]         n1_h [3];
    logic [47:0]           n1_box;
    logic [SUMW-1:0]       n1_sum;
    logic [CW-1:0]         n1_csph;

    logic                  r1_valid;
    t_op                   r1_op;
    logic [47:0]           r1_pos_a, r1_pos_b;
    logic signed [RW-1:0]  r1_rel [3];
    logic signed [AXW-1:0] r1_ax [3][3];
    logic [CB-1:0]         r1_h [3];
    logic [SUMW-1:0]       r1_sum;
    logic [CW-1:0]         r1_csph;

    always_comb begin
        n1_box = (i_op == OP_SB) ? i_ext_b : i_ext_a;
        n1_sum = '0;
        for (int i = 0; i < 3; i++) begin
            n1_pa[i] = $signed(fpart(i_pos_a, i));
            n1_pb[i] = $signed(fpart(i_pos_b, i));
            if (i_op == OP_BS) begin
                n1_rel[i] = RW'(n1_pb[i]) - RW'(n1_pa[i]);
            end else begin
                n1_rel[i] = RW'(n1_pa[i]) - RW'(n1_pb[i]);
            end
            n1_ax[0][i] = axpart(i_axis_u, i);
            n1_ax[1][i] = axpart(i_axis_v, i);
            n1_ax[2][i] = axpart(i_axis_w, i);
            n1_h[i]     = fpart(n1_box, i);
            n1_sum      = n1_sum + SUMW'(fpart(i_ext_a, i)) + SUMW'(fpart(i_ext_b, i));
        end
        case (i_op)
            OP_SS: n1_csph = CW'(fpart(i_ext_a, 0)) + CW'(fpart(i_ext_b, 0));
            OP_SB: n1_csph = CW'(fpart(i_ext_a, 0));
            OP_BS: n1_csph = CW'(fpart(i_ext_b, 0));
            default: n1_csph = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_op    <= i_op;
            r1_pos_a <= i_pos_a;
            r1_pos_b <= i_pos_b;
            r1_rel   <= n1_rel;
            r1_ax    <= n1_ax;
            r1_h     <= n1_h;
            r1_sum   <= n1_sum;
            r1_csph  <= n1_csph;
        end
    end

    // dot products and box-box contact
    logic signed [PRW-1:0] n2_prod [3][3];
    logic [SUMW+DIVK-1:0]  n2_mul;
    logic [CW-1:0]         n2_contact;

    logic                  r2_valid;
    t_op                   r2_op;
    logic [47:0]           r2_pos_a, r2_pos_b;
    logic signed [RW-1:0]  r2_rel [3];
    logic signed [AXW-1:0] r2_ax [3][3];
    logic [CB-1:0]         r2_h [3];
    logic [CW-1:0]         r2_contact;
    logic signed [PRW-1:0] r2_prod [3][3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                n2_prod[k][i] = PRW'(r1_rel[i]) * PRW'(r1_ax[k][i]);
            end
        end
        n2_mul = (SUMW+DIVK)'(r1_sum) * (SUMW+DIVK)'(RECIP3);
        n2_contact = (r1_op == OP_BB) ? CW'(n2_mul >> DIVK) : r1_csph;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_op      <= r1_op;
            r2_pos_a   <= r1_pos_a;
            r2_pos_b   <= r1_pos_b;
            r2_rel     <= r1_rel;
            r2_ax      <= r1_ax;
            r2_h       <= r1_h;
            r2_contact <= n2_contact;
            r2_prod    <= n2_prod;
        end
    end

    // round and clamp projections
    logic signed [TW-1:0]  n3_t [3];

    logic                  r3_valid;
    t_op                   r3_op;
    logic [47:0]           r3_pos_a, r3_pos_b;
    logic signed [RW-1:0]  r3_rel [3];
    logic signed [AXW-1:0] r3_ax [3][3];
    logic [CW-1:0]         r3_contact;
    logic signed [TW-1:0]  r3_t [3];

    always_comb begin
        logic signed [DOTW-1:0] dot;
        logic signed [63:0]     t;
        logic signed [63:0]     hh;
        for (int k = 0; k < 3; k++) begin
            dot = DOTW'(r2_prod[k][0]) + DOTW'(r2_prod[k][1]) + DOTW'(r2_prod[k][2]);
            t   = rnd_shr(64'(dot), AF);
            hh  = $signed(64'(r2_h[k]));
            if (t > hh) begin
                t = hh;
            end else if (t < -hh) begin
                t = -hh;
            end
            n3_t[k] = TW'(t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_op      <= r2_op;
            r3_pos_a   <= r2_pos_a;
            r3_pos_b   <= r2_pos_b;
            r3_rel     <= r2_rel;
            r3_ax      <= r2_ax;
            r3_contact <= r2_contact;
            r3_t       <= n3_t;
        end
    end

    // closest-point contributions
    logic signed [QPW-1:0] n4_q [3][3];

    logic                  r4_valid;
    t_op                   r4_op;
    logic [47:0]           r4_pos_a, r4_pos_b;
    logic signed [RW-1:0]  r4_rel [3];
    logic [CW-1:0]         r4_contact;
    logic signed [QPW-1:0] r4_q [3][3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                n4_q[k][i] = QPW'(r3_ax[k][i]) * QPW'(r3_t[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_op      <= r3_op;
            r4_pos_a   <= r3_pos_a;
            r4_pos_b   <= r3_pos_b;
            r4_rel     <= r3_rel;
            r4_contact <= r3_contact;
            r4_q       <= n4_q;
        end
    end

    // separation vector
    t_side n5_side;
    logic  r5_valid;
    t_side r5_side;

    always_comb begin
        logic signed [ACCW-1:0] acc;
        logic signed [63:0]     dv;
        logic                   box;
        box = (r4_op inside {OP_SB, OP_BS});
        n5_side.pos_a   = r4_pos_a;
        n5_side.pos_b   = r4_pos_b;
        n5_side.first_b = (r4_op == OP_BS);
        n5_side.fb_y    = box;
        n5_side.contact = r4_contact;
        for (int i = 0; i < 3; i++) begin
            acc = ACCW'(r4_q[0][i]) + ACCW'(r4_q[1][i]) + ACCW'(r4_q[2][i]);
            dv  = 64'(r4_rel[i]);
            if (box) begin
                dv = dv - rnd_shr(64'(acc), AF);
            end
            n5_side.d[i] = DW'(dv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_side <= n5_side;
        end
    end

    assign o_valid = r5_valid;
    assign o_side  = r5_side;

endmodule

/* rtl/cbr_sqrt.sv */
// Squared length and pipelined integer square root, two result bits a stage.
// Depends on cbr_pkg.
module cbr_sqrt import cbr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_side         i_side,
    output logic          o_valid,
    output t_side         o_side,
    output logic [LW-1:0] o_len
);

    logic [2*DW-1:0] n_sq [3];
    logic [2*DW-1:0] r_sq [3];
    logic            r_q1_valid;
    t_side           r_q1_side;

    logic [SQW-1:0]  r_x [SQ_ST+1];
    logic [SQW-1:0]  r_r [SQ_ST+1];
    logic            r_v [SQ_ST+1];
    t_side           r_sd [SQ_ST+1];
    logic [SQW-1:0]  n_x [SQ_ST];
    logic [SQW-1:0]  n_r [SQ_ST];
    logic [SQW-1:0]  n_sum;

    always_comb begin
        logic signed [2*DW-1:0] p;
        for (int i = 0; i < 3; i++) begin
            p = (2*DW)'($signed(i_side.d[i])) * (2*DW)'($signed(i_side.d[i]));
            n_sq[i] = p;
        end
        n_sum = SQW'(r_sq[0]) + SQW'(r_sq[1]) + SQW'(r_sq[2]);
    end

    always_comb begin
        logic [SQW-1:0] x;
        logic [SQW-1:0] r;
        logic [SQW-1:0] b;
        int             j;
        for (int s = 0; s < SQ_ST; s++) begin
            x = r_x[s];
            r = r_r[s];
            for (int m = 0; m < 2; m++) begin
                j = 2 * s + m;
                if (j < SQ_IT) begin
                    b = SQW'(1) << (SQW - 2 - 2 * j);
                    if (x >= r + b) begin
                        x = x - (r + b);
                        r = (r >> 1) + b;
                    end else begin
                        r = r >> 1;
                    end
                end
            end
            n_x[s] = x;
            n_r[s] = r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_valid <= 1'b0;
            for (int s = 0; s <= SQ_ST; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_q1_valid <= i_valid;
            r_v[0]     <= r_q1_valid;
            for (int s = 0; s < SQ_ST; s++) begin
                r_v[s+1] <= r_v[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq      <= n_sq;
            r_q1_side <= i_side;
            r_x[0]    <= n_sum;
            r_r[0]    <= '0;
            r_sd[0]   <= r_q1_side;
            for (int s = 0; s < SQ_ST; s++) begin
                r_x[s+1]  <= n_x[s];
                r_r[s+1]  <= n_r[s];
                r_sd[s+1] <= r_sd[s];
            end
        end
    end

    assign o_valid = r_v[SQ_ST];
    assign o_side  = r_sd[SQ_ST];
    assign o_len   = r_r[SQ_ST][LW-1:0];

endmodule

/* rtl/cbr_div.sv */
// Overlap, fallback test and pipelined restoring divide for the unit direction,
// one quotient bit a stage in three lanes. Depends on cbr_pkg.
module cbr_div import cbr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_side                i_side,
    input  logic [LW-1:0]        i_len,
    input  logic [EPW-1:0]       i_eps,
    output logic                 o_valid,
    output t_mid                 o_mid,
    output logic [2:0][QB-1:0]   o_q
);

    t_mid               n0_mid;
    logic [2:0][NW:0]   n0_rem;
    logic [LW:0]        n0_dv;

    logic [2:0][NW:0]   r_rem [QB+1];
    logic [2:0][QB-1:0] r_q [QB+1];
    logic [LW:0]        r_dv [QB+1];
    t_mid               r_mid [QB+1];
    logic               r_v [QB+1];
    logic [2:0][NW:0]   n_rem [QB];
    logic [2:0][QB-1:0] n_q [QB];

    always_comb begin
        logic [LW-1:0]        sep;
        logic signed [OW-1:0] ovs;
        logic [DW-1:0]        mag;
        n0_mid.side      = i_side;
        n0_mid.short_sep = (i_len < LW'(i_eps)) || (i_len == '0);
        sep              = n0_mid.short_sep ? LW'(i_eps) : i_len;
        ovs              = $signed(OW'(i_side.contact)) - $signed(OW'(sep));
        n0_mid.pushed    = (ovs > 0);
        n0_mid.ov        = n0_mid.pushed ? CW'(ovs) : '0;
        n0_dv            = (LW+1)'(i_len) << 1;
        for (int i = 0; i < 3; i++) begin
            mag = i_side.d[i][DW-1] ? DW'(-$signed(i_side.d[i])) : i_side.d[i];
            n0_rem[i] = ((NW+1)'(mag) << QB) + (NW+1)'(i_len);
        end
    end

    always_comb begin
        logic [NW:0] sub;
        for (int s = 0; s < QB; s++) begin
            n_q[s]   = r_q[s];
            n_rem[s] = r_rem[s];
            sub = (NW+1)'(r_dv[s]) << (QB - 1 - s);
            for (int i = 0; i < 3; i++) begin
                if (r_rem[s][i] >= sub) begin
                    n_rem[s][i] = r_rem[s][i] - sub;
                    n_q[s][i][QB-1-s] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QB; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 0; s < QB; s++) begin
                r_v[s+1] <= r_v[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n0_rem;
            r_q[0]   <= '0;
            r_dv[0]  <= n0_dv;
            r_mid[0] <= n0_mid;
            for (int s = 0; s < QB; s++) begin
                r_rem[s+1] <= n_rem[s];
                r_q[s+1]   <= n_q[s];
                r_dv[s+1]  <= r_dv[s];
                r_mid[s+1] <= r_mid[s];
            end
        end
    end

    assign o_valid = r_v[QB];
    assign o_mid   = r_mid[QB];
    assign o_q     = r_q[QB];

endmodule

/* rtl/cbr_move.sv */
// Back stages: direction sign, overlap split, moves, saturation and the
// output register. Depends on cbr_pkg.
module cbr_move import cbr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_mid               i_mid,
    input  logic [2:0][QB-1:0] i_q,
    input  logic [RTW-1:0]     i_ratio,
    output logic               o_valid,
    output logic [47:0]        o_pos_a,
    output logic [47:0]        o_pos_b,
    output logic               o_pushed
);

    logic signed [DRW-1:0] n1_dir [3];
    logic [CW+RTW-1:0]     n1_prod;
    logic                  r1_valid;
    logic signed [DRW-1:0] r1_dir [3];
    logic [CW+RTW-1:0]     r1_prod;
    t_mid                  r1_mid;

    always_comb begin
        logic hit;
        for (int i = 0; i < 3; i++) begin
            hit = i_mid.side.fb_y ? (i == 1) : (i == 0);
            if (i_mid.short_sep) begin
                n1_dir[i] = hit ? DRW'(1 << AF) : '0;
            end else if (i_mid.side.d[i][DW-1]) begin
                n1_dir[i] = -$signed(DRW'(i_q[i]));
            end else begin
                n1_dir[i] = $signed(DRW'(i_q[i]));
            end
        end
        n1_prod = (CW+RTW)'(i_mid.ov) * (CW+RTW)'(i_ratio);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dir  <= n1_dir;
            r1_prod <= n1_prod;
            r1_mid  <= i_mid;
        end
    end

    // split the overlap
    logic [CW-1:0]         n2_da;
    logic                  r2_valid;
    logic signed [DRW-1:0] r2_dir [3];
    logic [CW-1:0]         r2_da, r2_db;
    t_mid                  r2_mid;

    assign n2_da = CW'((r1_prod + ((CW+RTW)'(1) << 15)) >> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_dir <= r1_dir;
            r2_da  <= n2_da;
            r2_db  <= r1_mid.ov - n2_da;
            r2_mid <= r1_mid;
        end
    end

    // move products
    logic signed [MVW-1:0] n3_mf [3];
    logic signed [MVW-1:0] n3_ms [3];
    logic                  r3_valid;
    logic signed [MVW-1:0] r3_mf [3];
    logic signed [MVW-1:0] r3_ms [3];
    t_mid                  r3_mid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_mf[i] = MVW'(r2_dir[i]) * $signed(MVW'(r2_da));
            n3_ms[i] = MVW'(r2_dir[i]) * $signed(MVW'(r2_db));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_mf  <= n3_mf;
            r3_ms  <= n3_ms;
            r3_mid <= r2_mid;
        end
    end

    // apply, saturate, pack
    logic [47:0] n4_pos_a, n4_pos_b;
    logic        r_out_valid;
    logic [47:0] r_pos_a, r_pos_b;
    logic        r_pushed;

    always_comb begin
        logic signed [CB-1:0] ca;
        logic signed [CB-1:0] cs;
        logic signed [63:0]   nf;
        logic signed [63:0]   ns;
        logic [PW-1:0]        pk_a;
        logic [PW-1:0]        pk_b;
        pk_a = '0;
        pk_b = '0;
        for (int i = 0; i < 3; i++) begin
            ca = $signed(fpart(r3_mid.side.pos_a, i));
            cs = $signed(fpart(r3_mid.side.pos_b, i));
            if (r3_mid.side.first_b) begin
                nf = 64'(cs) + rnd_shr(64'(r3_mf[i]), AF);
                ns = 64'(ca) - rnd_shr(64'(r3_ms[i]), AF);
                pk_a[i*CB +: CB] = sat_c(ns);
                pk_b[i*CB +: CB] = sat_c(nf);
            end else begin
                nf = 64'(ca) + rnd_shr(64'(r3_mf[i]), AF);
                ns = 64'(cs) - rnd_shr(64'(r3_ms[i]), AF);
                pk_a[i*CB +: CB] = sat_c(nf);
                pk_b[i*CB +: CB] = sat_c(ns);
            end
        end
        n4_pos_a = r3_mid.pushed ? pk_a[47:0] : r3_mid.side.pos_a;
        n4_pos_b = r3_mid.pushed ? pk_b[47:0] : r3_mid.side.pos_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos_a  <= n4_pos_a;
            r_pos_b  <= n4_pos_b;
            r_pushed <= r3_mid.pushed;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_pos_a  = r_pos_a;
    assign o_pos_b  = r_pos_b;
    assign o_pushed = r_pushed;

endmodule

/* rtl/collision_push_back_resolver.sv */
// Top level of the collision push-back resolver: config registers, stall
// control, pipeline front to back. Depends on cbr_pkg, cbr_geom, cbr_sqrt,
// cbr_div, cbr_move.
//
//   channel   dir  handshake                 payload
//   s         in   i_s_tvalid / o_s_tready   tdata 336b, tuser 2b
//   m         out  o_m_tvalid / i_m_tready   tdata 96b,  tuser 1b
//   cfg       in   i_cfg_we                  i_cfg_idx, i_cfg_data 17b
//
// One word enters per cycle while the output is not stalled. The pipeline runs
// the front stages, the 23-step root, the 15-bit divide and the back stages.
// Reset clears the valid bits and loads the config defaults; no sweep.
// A stall on the output freezes every stage at once, so nothing is lost.
module collision_push_back_resolver import cbr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // pos_a, pos_b, extent_a, extent_b, axis_u, axis_v, axis_w
    input  logic [335:0]  i_s_tdata,
    // operation
    input  logic [1:0]    i_s_tuser,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // new_pos_a, new_pos_b
    output logic [95:0]   o_m_tdata,
    // pushed
    output logic [0:0]    o_m_tuser,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_idx,
    input  logic [RTW-1:0] i_cfg_data
);

    logic [RTW-1:0] r_push_ratio;
    logic [EPW-1:0] r_epsilon;
    logic [RTW-1:0] w_ratio;
    logic           w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push_ratio <= RTW'(32768);
            r_epsilon    <= EPW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PUSH_RATIO: r_push_ratio <= i_cfg_data;
                CFG_EPSILON:    r_epsilon    <= i_cfg_data[EPW-1:0];
                default: ;
            endcase
        end
    end

    assign w_ratio    = (r_push_ratio > RATIO_ONE) ? RATIO_ONE : r_push_ratio;
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    logic               w_g_valid;
    t_side              w_g_side;
    logic               w_s_valid;
    t_side              w_s_side;
    logic [LW-1:0]      w_s_len;
    logic               w_d_valid;
    t_mid               w_d_mid;
    logic [2:0][QB-1:0] w_d_q;

    cbr_geom u_geom (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_s_tvalid),
        .i_op     (t_op'(i_s_tuser)),
        .i_pos_a  (i_s_tdata[47:0]),
        .i_pos_b  (i_s_tdata[95:48]),
        .i_ext_a  (i_s_tdata[143:96]),
        .i_ext_b  (i_s_tdata[191:144]),
        .i_axis_u (i_s_tdata[239:192]),
        .i_axis_v (i_s_tdata[287:240]),
        .i_axis_w (i_s_tdata[335:288]),
        .o_valid  (w_g_valid),
        .o_side   (w_g_side)
    );

    cbr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_g_valid),
        .i_side  (w_g_side),
        .o_valid (w_s_valid),
        .o_side  (w_s_side),
        .o_len   (w_s_len)
    );

    cbr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_valid),
        .i_side  (w_s_side),
        .i_len   (w_s_len),
        .i_eps   (r_epsilon),
        .o_valid (w_d_valid),
        .o_mid   (w_d_mid),
        .o_q     (w_d_q)
    );

    cbr_move u_move (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_d_valid),
        .i_mid    (w_d_mid),
        .i_q      (w_d_q),
        .i_ratio  (w_ratio),
        .o_valid  (o_m_tvalid),
        .o_pos_a  (o_m_tdata[47:0]),
        .o_pos_b  (o_m_tdata[95:48]),
        .o_pushed (o_m_tuser[0])
    );

endmodule

/* rtl/cbr_checker.sv */
// Port-level checks for the collision push-back resolver, bound to the top.
// Depends only on the top-level port list.
module cbr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_s_tready,
    input logic           o_m_tvalid,
    input logic           i_m_tready,
    input logic [95:0]    o_m_tdata,
    input logic [0:0]     o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output word changed while stalled");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind collision_push_back_resolver cbr_checker u_cbr_checker (.*);
